/* src/spdp_pkg.sv */
// ----------------------------------------------------------------------------
// spdp_pkg
// Shared types and constants of the scan pixel depth packer.
// ----------------------------------------------------------------------------
`default_nettype none

package spdp_pkg;

   localparam int unsigned MAX_WIDTH_DEF = 16384;

   localparam int IMAGE_WIDTH_W = 15;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 15;
   localparam int RESULT_DEPTH  = 3;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MODE  = 2'd1;

   // grey quantizer thresholds and the bilevel output bit
   localparam logic [7:0] GREY_LEVEL_3 = 8'd192;
   localparam logic [7:0] GREY_LEVEL_2 = 8'd128;
   localparam logic [7:0] GREY_LEVEL_1 = 8'd64;
   localparam logic [7:0] BILEVEL_BIT  = 8'h80;

   typedef enum logic [1:0] {
      MODE_RGB     = 2'd0,
      MODE_GREY8   = 2'd1,
      MODE_GREY2   = 2'd2,
      MODE_BILEVEL = 2'd3
   } pixel_mode_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last_of_pixel;
      logic       row_end;
   } out_entry_type;

   function automatic logic [1:0] grey_quantize(input logic [7:0] value);
      logic [1:0] q;
      if (value >= GREY_LEVEL_3) begin
         q = 2'd3;
      end else if (value >= GREY_LEVEL_2) begin
         q = 2'd2;
      end else if (value >= GREY_LEVEL_1) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

/* src/scan_pixel_depth_packer_unit.sv */
// ----------------------------------------------------------------------------
// scan_pixel_depth_packer_unit
// Packs one RGB pixel per item into image stream bytes (rgb, grey 8-bit,
// grey 2-bit, bilevel), padding each row to a byte boundary.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    red, green, blue
//   rsp      out        rsp_valid/ready    packed_byte, last_of_pixel, row_end
//   csr      in         csr_write_en       csr_index, csr_wdata
//
// An item is packed in the cycle it is accepted; its bytes leave from a
// three-entry result buffer, one byte per cycle while rsp_ready is high.
// Rgb mode puts three bytes per item through the one output port, the
// other modes at most one. A new item is taken as the last byte leaves.
// Reset is synchronous; it empties the buffer, clears the column and the
// partial byte, and sets image_width to 1 and pixel_mode to rgb.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_pixel_depth_packer_unit #(
   parameter int unsigned MAX_WIDTH = spdp_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_red,
   input  wire logic [7:0]                         req_green,
   input  wire logic [7:0]                         req_blue,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_packed_byte,
   output logic                                    rsp_last_of_pixel,
   output logic                                    rsp_row_end,
   input  wire logic                               csr_write_en,
   input  wire logic [spdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [spdp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import spdp_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = (COL_W + 1 > IMAGE_WIDTH_W) ? COL_W + 1 : IMAGE_WIDTH_W;

   logic [IMAGE_WIDTH_W-1:0] image_width_ff;
   pixel_mode_type           pixel_mode_ff;
   logic [COL_W-1:0]         column_ff, column_in;
   logic [7:0]               partial_ff, partial_in;
   logic [2:0]               bit_pos_ff, bit_pos_in;
   logic [1:0]               count_ff, count_in;
   out_entry_type            entry_ff [RESULT_DEPTH];
   out_entry_type            entry_in [RESULT_DEPTH];

   logic                     accept, pop;
   logic [CMP_W-1:0]         width_ext, width_eff, col_next;
   logic                     last_col;
   logic [7:0]               slot_bits, merged;
   logic [3:0]               filled, nbits;
   logic [1:0]               n_res;
   out_entry_type            res [RESULT_DEPTH];

   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_valid         = (count_ff != 2'd0);
   assign rsp_packed_byte   = entry_ff[0].packed_byte;
   assign rsp_last_of_pixel = entry_ff[0].last_of_pixel;
   assign rsp_row_end       = entry_ff[0].row_end;

   // row end against the clamped width
   always_comb begin
      width_ext = CMP_W'(image_width_ff);
      if (width_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_next  = CMP_W'(column_ff) + CMP_W'(1);
      last_col  = (col_next >= width_eff);
      column_in = last_col ? '0 : col_next[COL_W-1:0];
   end

   // pack the pixel and form its results
   always_comb begin
      if (pixel_mode_ff == MODE_GREY2) begin
         slot_bits = {grey_quantize(req_red), 6'd0};
         nbits     = 4'd2;
      end else begin
         slot_bits = (req_red != 8'd0) ? BILEVEL_BIT : 8'd0;
         nbits     = 4'd1;
      end
      merged = partial_ff | (slot_bits >> bit_pos_ff);
      filled = {1'b0, bit_pos_ff} + nbits;

      res[0]     = '{packed_byte: req_red, last_of_pixel: 1'b1, row_end: last_col};
      res[1]     = '{packed_byte: req_green, last_of_pixel: 1'b0, row_end: 1'b0};
      res[2]     = '{packed_byte: req_blue, last_of_pixel: 1'b1, row_end: last_col};
      n_res      = 2'd1;
      partial_in = 8'd0;
      bit_pos_in = 3'd0;

      unique case (pixel_mode_ff) inside
         MODE_RGB: begin
            res[0].last_of_pixel = 1'b0;
            res[0].row_end       = 1'b0;
            n_res                = 2'd3;
         end
         MODE_GREY8: begin
            n_res = 2'd1;
         end
         MODE_GREY2, MODE_BILEVEL: begin
            res[0].packed_byte = merged;
            if ((filled >= 4'd8) || last_col) begin
               n_res = 2'd1;
            end else begin
               // hold the gathered bits for the next pixel
               n_res      = 2'd0;
               partial_in = merged;
               bit_pos_in = filled[2:0];
            end
         end
         default: begin
            n_res = 2'd1;
         end
      endcase
   end

   // result buffer: load on accept, else shift on pop
   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (accept) begin
         entry_in = res;
         count_in = n_res;
      end else if (pop) begin
         entry_in[0] = entry_ff[1];
         entry_in[1] = entry_ff[2];
         count_in    = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         count_ff   <= 2'd0;
         column_ff  <= '0;
         partial_ff <= 8'd0;
         bit_pos_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            column_ff  <= column_in;
            partial_ff <= partial_in;
            bit_pos_ff <= bit_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_W'(1);
         pixel_mode_ff  <= MODE_RGB;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[IMAGE_WIDTH_W-1:0];
            CSR_PIXEL_MODE:  pixel_mode_ff  <= pixel_mode_type'(csr_wdata[1:0]);
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* src/scan_pixel_depth_packer_checker.sv */
// ----------------------------------------------------------------------------
// scan_pixel_depth_packer_checker
// Port-level checks of the packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_pixel_depth_packer_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_packed_byte,
   input wire logic       rsp_last_of_pixel,
   input wire logic       rsp_row_end
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_byte)
         && $stable(rsp_last_of_pixel) && $stable(rsp_row_end))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a row ends only on the final byte of a pixel
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_last_of_pixel)
      else $error("row end on a non-final byte");

   // bytes of one pixel follow without a gap
   a_pixel_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_pixel |=> rsp_valid)
      else $error("gap inside a pixel's bytes");

   // an empty output side always takes an item
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("not ready with no result pending");

endmodule

bind scan_pixel_depth_packer_unit scan_pixel_depth_packer_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_packed_byte   (rsp_packed_byte),
   .rsp_last_of_pixel (rsp_last_of_pixel),
   .rsp_row_end       (rsp_row_end)
);

`default_nettype wire
